/* rtl/core/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// checked while out of reset
`define AST_SYNC(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define AST_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AST_SYNC(label, prop, msg)
`define AST_ALWAYS(label, prop, msg)
`endif
`endif

/* rtl/core/fpba_pkg.sv */
// Shared types and codes for the fit-policy block allocator.
// No dependencies; used by fpba_scan and the allocator top level.
package fpba_pkg;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // placement policy codes (the unused code behaves as first fit)
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // input word
  typedef struct packed {
    logic        command;
    logic [2:0]  block_index;
    logic [15:0] size_value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic        granted;
    logic [2:0]  chosen_block;
    logic [15:0] remaining_size;
  } out_word_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic       clear;
    logic       en;
    logic [1:0] policy;
  } scan_ctl_t;

endpackage

/* rtl/core/fpba_table.sv */
// Free-size table: one write port, one registered read port, per-entry valid bits.
// Entries never written read as zero. Depends on nothing outside this file.
module fpba_table #(
  parameter int NUM_BLOCKS = 8,
  parameter int SIZE_WIDTH = 16,
  parameter int AW         = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [SIZE_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [SIZE_WIDTH-1:0] rd_data
);

  logic [SIZE_WIDTH-1:0] mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] valid_r;
  logic [SIZE_WIDTH-1:0] mem_q_r;
  logic                  rd_valid_r;

  // storage array, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // valid bits stand in for the reset clear of the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? mem_q_r : '0;

endmodule

/* rtl/core/fpba_scan.sv */
// Compare unit: looks at one table entry per cycle while enabled and keeps the pick so far.
// Depends on fpba_pkg (policy codes, control struct).
module fpba_scan #(
  parameter int SIZE_WIDTH = 16,
  parameter int AW         = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fpba_pkg::scan_ctl_t   ctl,
  input  logic [AW-1:0]         entry_idx,
  input  logic [SIZE_WIDTH-1:0] entry_size,
  input  logic [SIZE_WIDTH-1:0] req_size,
  output logic                  found,
  output logic [AW-1:0]         pick,
  output logic [SIZE_WIDTH-1:0] best_size
);

  logic                  found_r, found_nxt;
  logic [AW-1:0]         pick_r, pick_nxt;
  logic [SIZE_WIDTH-1:0] best_r, best_nxt;
  logic                  fits;
  logic                  take;

  // one fit compare and one ranking compare per entry
  always_comb begin
    fits = (entry_size >= req_size);
    take = 1'b0;
    if (fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else begin
        case (ctl.policy)
          fpba_pkg::POL_BEST:  take = (best_r >= entry_size); // tie: later index
          fpba_pkg::POL_WORST: take = (best_r < entry_size);  // tie: earlier index
          default:             take = 1'b0;                   // first fit keeps it
        endcase
      end
    end
  end

  always_comb begin
    found_nxt = found_r;
    pick_nxt  = pick_r;
    best_nxt  = best_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (ctl.en && take) begin
      found_nxt = 1'b1;
      pick_nxt  = entry_idx;
      best_nxt  = entry_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    pick_r <= pick_nxt;
    best_r <= best_nxt;
  end

  assign found     = found_r;
  assign pick      = pick_r;
  assign best_size = best_r;

endmodule

/* rtl/core/fit_policy_block_allocator_top.sv */
// Top level of the fit-policy block allocator: sequencer, policy register, result port.
// Depends on fpba_pkg, fpba_table, fpba_scan and assert_macros.svh.
//
//   channel  ports                       direction  transfer
//   input    start, busy, in_data        in         start && !busy
//   result   out_strobe, out_data        out        out_strobe, one cycle
//   config   cfg_we, cfg_wdata           in         cfg_we
//
// A load word keeps busy high in the load state; its result strobes the cycle after.
// An allocate word keeps busy high through the scan, drain and commit states: the
// table is read one entry per cycle through its single registered read port in
// scan, drain finishes the compare, and commit writes back the reduced size.
// rst_n is synchronous; it clears the table valid bits at once, no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
module fit_policy_block_allocator_top #(
  parameter int NUM_BLOCKS = 8,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fpba_pkg::in_word_t  in_data,
  output logic                out_strobe,
  output fpba_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata
);

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [1:0]            policy_r;
  logic [2:0]            idx_r, idx_nxt;
  logic [SIZE_WIDTH-1:0] size_r, size_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic                  rd_en_r;
  logic [AW-1:0]         rd_idx_r;
  logic                  out_strobe_r, out_strobe_nxt;
  fpba_pkg::out_word_t   out_data_r, out_data_nxt;

  logic                  accept;
  logic [31:0]           in_size_ext;
  logic [31:0]           idx_ext;
  logic                  load_in_range;
  logic                  tbl_wr_en;
  logic [AW-1:0]         tbl_wr_addr;
  logic [SIZE_WIDTH-1:0] tbl_wr_data;
  logic                  tbl_rd_en;
  logic [SIZE_WIDTH-1:0] tbl_rd_data;
  fpba_pkg::scan_ctl_t   scan_ctl;
  logic                  scan_found;
  logic [AW-1:0]         scan_pick;
  logic [SIZE_WIDTH-1:0] scan_best;
  logic [SIZE_WIDTH-1:0] remain;
  logic [31:0]           remain_ext;
  logic [31:0]           pick_ext;
  logic [31:0]           load_ext;

  assign accept        = start && !busy;
  assign in_size_ext   = 32'(in_data.size_value);
  assign idx_ext       = 32'(idx_r);
  assign load_in_range = (idx_ext < 32'(NUM_BLOCKS));
  assign remain        = scan_best - size_r;
  assign remain_ext    = 32'(remain);
  assign pick_ext      = 32'(scan_pick);
  assign load_ext      = 32'(size_r);

  // policy register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fpba_pkg::POL_FIRST;
    end else if (cfg_we) begin
      policy_r <= cfg_wdata;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    size_nxt       = size_r;
    addr_nxt       = addr_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt   = in_data.block_index;
          size_nxt  = in_size_ext[SIZE_WIDTH-1:0];
          addr_nxt  = '0;
          state_nxt = (in_data.command == fpba_pkg::CMD_LOAD) ? ST_LOAD : ST_SCAN;
        end
      end
      ST_LOAD: begin
        out_strobe_nxt              = 1'b1;
        out_data_nxt.granted        = 1'b0;
        out_data_nxt.chosen_block   = idx_r;
        out_data_nxt.remaining_size = load_in_range ? load_ext[15:0] : '0;
        state_nxt                   = ST_IDLE;
      end
      ST_SCAN: begin
        if (addr_r == AW'(NUM_BLOCKS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        out_strobe_nxt = 1'b1;
        if (scan_found) begin
          out_data_nxt.granted        = 1'b1;
          out_data_nxt.chosen_block   = pick_ext[2:0];
          out_data_nxt.remaining_size = remain_ext[15:0];
        end else begin
          out_data_nxt = '0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_en_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_en_r      <= tbl_rd_en;
      out_strobe_r <= out_strobe_nxt;
    end
    idx_r      <= idx_nxt;
    size_r     <= size_nxt;
    addr_r     <= addr_nxt;
    rd_idx_r   <= addr_r;
    out_data_r <= out_data_nxt;
  end

  // table access
  assign tbl_rd_en   = (state_r == ST_SCAN);
  assign tbl_wr_en   = ((state_r == ST_LOAD) && load_in_range) ||
                       ((state_r == ST_COMMIT) && scan_found);
  assign tbl_wr_addr = (state_r == ST_LOAD) ? idx_ext[AW-1:0] : scan_pick;
  assign tbl_wr_data = (state_r == ST_LOAD) ? size_r : remain;

  fpba_table #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH),
    .AW         (AW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (addr_r),
    .rd_data (tbl_rd_data)
  );

  // compare unit fed one entry per cycle during a scan
  always_comb begin
    scan_ctl.clear  = accept;
    scan_ctl.en     = rd_en_r;
    scan_ctl.policy = policy_r;
  end

  fpba_scan #(
    .SIZE_WIDTH (SIZE_WIDTH),
    .AW         (AW)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .entry_idx  (rd_idx_r),
    .entry_size (tbl_rd_data),
    .req_size   (size_r),
    .found      (scan_found),
    .pick       (scan_pick),
    .best_size  (scan_best)
  );

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // checks
`include "assert_macros.svh"

  `AST_SYNC(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `AST_SYNC(a_strobe_idle, out_strobe |-> !busy, "result strobed while still busy")
  `AST_SYNC(a_commit_out, (state_r == ST_COMMIT) |=> out_strobe, "allocate gave no result")
  `AST_SYNC(a_no_grant_zero, (out_strobe && !out_data.granted && $past(state_r == ST_COMMIT)) |-> (out_data.remaining_size == '0), "failed allocate reported a size")

endmodule
